// File: rtl/sle_pkg.sv
// Shared types and constants for the sequential list engine.
// Used by the controller, datapath, top level and bench; depends on nothing.
`timescale 1ns / 1ps

package sle_pkg;

	// List geometry
	localparam int CAPACITY = 64;
	localparam int ADDR_W   = $clog2(CAPACITY);
	localparam int LEN_W    = 7;
	localparam int POS_W    = 8;
	localparam int DATA_W   = 8;
	localparam int MODE_W   = 3;

	// Operation codes
	localparam logic [MODE_W-1:0] MODE_GET    = 3'd0;
	localparam logic [MODE_W-1:0] MODE_LOCATE = 3'd1;
	localparam logic [MODE_W-1:0] MODE_INSERT = 3'd2;
	localparam logic [MODE_W-1:0] MODE_DELETE = 3'd3;
	localparam logic [MODE_W-1:0] MODE_CLEAR  = 3'd4;

	// Request item
	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic [POS_W-1:0]  position;
		logic [DATA_W-1:0] value;
	} sle_req_t;

	// Response item
	typedef struct packed {
		logic              ok;
		logic [DATA_W-1:0] element;
		logic [LEN_W-1:0]  found_position;
		logic [LEN_W-1:0]  count;
		logic              is_empty;
	} sle_rsp_t;

	// Controller to datapath
	typedef struct packed {
		logic load;    // capture the accepted request
		logic init;    // set up the walk pointers
		logic step;    // advance the walk by one memory access
		logic finish;  // commit length, final write and response
	} sle_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic walk_needed;  // request is valid and touches the store
		logic walk_done;    // no read in flight and none left to issue, or a locate hit
	} sle_sts_t;

endpackage

// File: rtl/sle_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; no package needed.
`timescale 1ns / 1ps

module sle_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: rtl/sle_datapath.sv
// Datapath of the list engine: request and length registers, walk pointers,
// list store and response register. Depends on sle_pkg and sle_ram.
`timescale 1ns / 1ps

module sle_datapath import sle_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  sle_req_t req,
	input  sle_cmd_t cmd,
	output sle_sts_t sts,
	output sle_rsp_t rsp
);

	sle_req_t          req_q;
	logic [LEN_W-1:0]  len_q;
	logic [ADDR_W-1:0] rp_q;
	logic [LEN_W-1:0]  rem_q;
	logic [ADDR_W-1:0] lp_q;
	logic              lv_q;
	logic              hit_q;
	logic [DATA_W-1:0] elem_q;
	logic [LEN_W-1:0]  found_q;
	sle_rsp_t          rsp_q;

	logic [POS_W:0]    pos_ext;
	logic [POS_W:0]    len_ext;
	logic [POS_W-1:0]  pos_m1;
	logic [ADDR_W-1:0] p_addr;
	logic [POS_W:0]    shift_cnt;
	logic              pos_in_list;
	logic              pos_in_ins;
	logic              req_ok;
	logic              match;
	logic [LEN_W-1:0]  len_next;

	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	logic [DATA_W-1:0] ram_wdata;
	logic [DATA_W-1:0] ram_rdata;

	// Position checks against the current length
	assign pos_ext     = {1'b0, req_q.position};
	assign len_ext     = (POS_W + 1)'(len_q);
	assign pos_m1      = req_q.position - POS_W'(1);
	assign p_addr      = pos_m1[ADDR_W-1:0];
	assign shift_cnt   = len_ext + (POS_W + 1)'(1) - pos_ext;
	assign pos_in_list = (req_q.position != '0) && (pos_ext <= len_ext);
	assign pos_in_ins  = (req_q.position != '0) && (pos_ext <= len_ext + (POS_W + 1)'(1)) &&
		(len_q < LEN_W'(CAPACITY));

	always_comb begin
		case (req_q.mode)
			MODE_GET:    req_ok = pos_in_list;
			MODE_LOCATE: req_ok = 1'b1;
			MODE_INSERT: req_ok = pos_in_ins;
			MODE_DELETE: req_ok = pos_in_list;
			MODE_CLEAR:  req_ok = 1'b1;
			default:     req_ok = 1'b0;
		endcase
	end

	assign sts.walk_needed = req_ok && (req_q.mode != MODE_CLEAR);
	assign sts.walk_done   = ((rem_q == '0) && !lv_q) || hit_q;

	// First match of a locate walk
	assign match = lv_q && !hit_q && (req_q.mode == MODE_LOCATE) && (ram_rdata == req_q.value);

	// Store write: final insert write, or one shifted element per walk step
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = lp_q;
		ram_wdata = ram_rdata;
		if (cmd.finish && req_ok && (req_q.mode == MODE_INSERT)) begin
			ram_we    = 1'b1;
			ram_waddr = p_addr;
			ram_wdata = req_q.value;
		end else if (cmd.step && lv_q) begin
			if (req_q.mode == MODE_INSERT) begin
				ram_we    = 1'b1;
				ram_waddr = lp_q + ADDR_W'(1);
			end else if ((req_q.mode == MODE_DELETE) && (lp_q != p_addr)) begin
				ram_we    = 1'b1;
				ram_waddr = lp_q - ADDR_W'(1);
			end
		end
	end

	sle_ram #(
		.WIDTH(DATA_W),
		.DEPTH(CAPACITY)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(rp_q),
		.rdata(ram_rdata)
	);

	// Length after the operation
	always_comb begin
		len_next = len_q;
		if (req_ok) begin
			case (req_q.mode)
				MODE_INSERT: len_next = len_q + LEN_W'(1);
				MODE_DELETE: len_next = len_q - LEN_W'(1);
				MODE_CLEAR:  len_next = '0;
				default:     len_next = len_q;
			endcase
		end
	end

	// Control registers: length and walk state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
			rem_q <= '0;
			lv_q  <= 1'b0;
			hit_q <= 1'b0;
		end else if (cmd.init) begin
			lv_q  <= 1'b0;
			hit_q <= 1'b0;
			case (req_q.mode)
				MODE_GET:    rem_q <= req_ok ? LEN_W'(1) : '0;
				MODE_LOCATE: rem_q <= len_q;
				MODE_INSERT: rem_q <= req_ok ? LEN_W'(shift_cnt) : '0;
				MODE_DELETE: rem_q <= req_ok ? LEN_W'(shift_cnt) : '0;
				default:     rem_q <= '0;
			endcase
		end else if (cmd.step) begin
			if ((rem_q != '0) && !match && !hit_q) begin
				rem_q <= rem_q - LEN_W'(1);
				lv_q  <= 1'b1;
			end else begin
				lv_q <= 1'b0;
			end
			if (match) begin
				hit_q <= 1'b1;
			end
		end else if (cmd.finish) begin
			len_q <= len_next;
		end
	end

	// Request capture, walk pointers and gathered results
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= req;
		end
		if (cmd.init) begin
			elem_q  <= '0;
			found_q <= '0;
			case (req_q.mode)
				MODE_LOCATE: rp_q <= '0;
				MODE_INSERT: rp_q <= len_q[ADDR_W-1:0] - ADDR_W'(1);
				default:     rp_q <= p_addr;
			endcase
		end else if (cmd.step) begin
			if ((rem_q != '0) && !match && !hit_q) begin
				rp_q <= (req_q.mode == MODE_INSERT) ? rp_q - ADDR_W'(1) : rp_q + ADDR_W'(1);
				lp_q <= rp_q;
			end
			if (match) begin
				found_q <= LEN_W'(lp_q) + LEN_W'(1);
			end
			if (lv_q && ((req_q.mode == MODE_GET) ||
				((req_q.mode == MODE_DELETE) && (lp_q == p_addr)))) begin
				elem_q <= ram_rdata;
			end
		end
		if (cmd.finish) begin
			rsp_q.ok             <= req_ok;
			rsp_q.element        <= elem_q;
			rsp_q.found_position <= found_q;
			rsp_q.count          <= len_next;
			rsp_q.is_empty       <= (len_next == '0);
		end
	end

	assign rsp = rsp_q;

endmodule

// File: rtl/sle_ctrl.sv
// Controller of the list engine: sequences load, setup, walk and commit,
// and owns the input stall and the output valid. Depends on sle_pkg.
`timescale 1ns / 1ps

module sle_ctrl import sle_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_stall,
	output logic     rsp_valid,
	input  logic     rsp_stall,
	input  sle_sts_t sts,
	output sle_cmd_t cmd
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_START = 2'd1;
	localparam logic [1:0] ST_WALK  = 2'd2;
	localparam logic [1:0] ST_DONE  = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_next;
	logic       out_valid_q;
	logic       slot_free;

	assign slot_free = !out_valid_q || !rsp_stall;
	assign req_stall = (state_q != ST_IDLE);
	assign rsp_valid = out_valid_q;

	// Next state and commands
	always_comb begin
		state_next = state_q;
		cmd        = '0;
		case (state_q)
			ST_IDLE: begin
				cmd.load = req_valid;
				if (req_valid) begin
					state_next = ST_START;
				end
			end
			ST_START: begin
				cmd.init   = 1'b1;
				state_next = sts.walk_needed ? ST_WALK : ST_DONE;
			end
			ST_WALK: begin
				cmd.step = 1'b1;
				if (sts.walk_done) begin
					state_next = ST_DONE;
				end
			end
			ST_DONE: begin
				if (slot_free) begin
					cmd.finish = 1'b1;
					state_next = ST_IDLE;
				end
			end
			default: state_next = ST_IDLE;
		endcase
	end

	// State and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// File: rtl/sequential_list_engine_core.sv
// Top level of the sequential list engine: controller plus datapath.
// Depends on sle_pkg, sle_ctrl, sle_datapath and sle_ram.
//
// Usage:
// - Request channel req_valid / req_stall / req carries one item: mode,
//   1-based position and value. It is taken when req_valid is high and
//   req_stall low; req_stall is high while an item is in work.
// - Response channel rsp_valid / rsp_stall / rsp carries one item per
//   request: ok, element, found_position, count and is_empty.
// - Timing: a setup step, then (for a valid request other than a clear) a
//   walk over the store with one memory access per cycle, then a commit
//   step that waits until the output register is free. The response
//   becomes valid as the block returns to idle, where it can take the next
//   item. The store's read port sets the walk rate.
// - The response sits in an output register; the next request is accepted
//   while it waits. If rsp_stall stays high, the following item finishes
//   its walk and holds in its commit cycle until the register frees.
// - Reset clears the length to zero and empties both channels; the store
//   contents are not cleared and are only read after being written.
`timescale 1ns / 1ps

module sequential_list_engine_core import sle_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_stall,
	input  sle_req_t req,
	output logic     rsp_valid,
	input  logic     rsp_stall,
	output sle_rsp_t rsp
);

	sle_cmd_t cmd;
	sle_sts_t sts;

	sle_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	sle_datapath u_datapath (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req),
		.cmd   (cmd),
		.sts   (sts),
		.rsp   (rsp)
	);

endmodule

// File: tb/tb_sequential_list_engine_core.sv
// Self-checking bench for sequential_list_engine_core: a directed table, then random
// list traffic, checked against a behavioral list model. Depends on sle_pkg and the RTL.
`timescale 1ns / 1ps

module tb_sequential_list_engine_core;
	import sle_pkg::*;

	localparam int RESET_CYCLES = 12;
	localparam int RANDOM_ITEMS = 450;
	localparam int QUIET_LIMIT  = 3000;  // cycles with no handshake before giving up
	localparam int DRAIN_CYCLES = 100;   // longest walk plus margin
	localparam int HOLD_CYCLES  = 250;   // long receiver hold-off

	// Mode codes the block must reject
	localparam logic [MODE_W-1:0] MODE_UNUSED_5 = 3'd5;
	localparam logic [MODE_W-1:0] MODE_UNUSED_6 = 3'd6;
	localparam logic [MODE_W-1:0] MODE_UNUSED_7 = 3'd7;

	typedef struct packed {
		sle_req_t r;
		logic     typed;  // response below is typed in, not predicted
		sle_rsp_t want;
	} list_case_t;

	logic     clk = 1'b0;
	logic     arst_n;
	logic     req_valid;
	logic     req_stall;
	sle_req_t req;
	logic     rsp_valid;
	logic     rsp_stall;
	sle_rsp_t rsp;

	// Shadow copy of the list
	logic [DATA_W-1:0] list_mem [CAPACITY];
	int                list_len;

	sle_rsp_t   rsp_q [$];
	list_case_t cases [$];
	int         err_cnt = 0;
	int         quiet_cycles = 0;
	int         idle_pct;
	int         stall_pct;
	bit         long_hold;
	bit         filling;

	sequential_list_engine_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always #2 clk = ~clk;

	// Apply one operation to the shadow list and return its response
	function automatic sle_rsp_t apply_list_op(sle_req_t r);
		sle_rsp_t o;
		int       p;
		int       j;
		o = '0;
		p = r.position;
		case (r.mode)
			MODE_GET: begin
				if (p >= 1 && p <= list_len) begin
					o.element = list_mem[p-1];
					o.ok = 1'b1;
				end
			end
			MODE_LOCATE: begin
				for (j = 0; j < list_len; j++) begin
					if (list_mem[j] == r.value) begin
						o.found_position = LEN_W'(j + 1);
						break;
					end
				end
				o.ok = 1'b1;
			end
			MODE_INSERT: begin
				if (list_len < CAPACITY && p >= 1 && p <= list_len + 1) begin
					for (j = list_len; j > p - 1; j--)
						list_mem[j] = list_mem[j-1];
					list_mem[p-1] = r.value;
					list_len++;
					o.ok = 1'b1;
				end
			end
			MODE_DELETE: begin
				if (p >= 1 && p <= list_len) begin
					o.element = list_mem[p-1];
					for (j = p - 1; j + 1 < list_len; j++)
						list_mem[j] = list_mem[j+1];
					list_len--;
					o.ok = 1'b1;
				end
			end
			MODE_CLEAR: begin
				list_len = 0;
				o.ok = 1'b1;
			end
			default: ;
		endcase
		o.count = LEN_W'(list_len);
		o.is_empty = (list_len == 0);
		return o;
	endfunction

	// Random request; alternates between filling the list up and draining it
	function automatic sle_req_t next_list_request();
		sle_req_t r;
		int       pick;
		int       roll;
		int       top;
		if (list_len == CAPACITY)
			filling = 1'b0;
		else if (list_len == 0)
			filling = 1'b1;
		r.value = DATA_W'($urandom_range(0, 1) ? $urandom_range(0, 7) : $urandom_range(0, 255));
		pick = $urandom_range(0, 99);
		if (filling) begin
			if (pick < 60)      r.mode = MODE_INSERT;
			else if (pick < 70) r.mode = MODE_DELETE;
			else if (pick < 80) r.mode = MODE_GET;
			else if (pick < 97) r.mode = MODE_LOCATE;
			else                r.mode = MODE_W'($urandom_range(MODE_UNUSED_5, MODE_UNUSED_7));
		end else begin
			if (pick < 20)      r.mode = MODE_INSERT;
			else if (pick < 55) r.mode = MODE_DELETE;
			else if (pick < 70) r.mode = MODE_GET;
			else if (pick < 90) r.mode = MODE_LOCATE;
			else if (pick < 94) r.mode = MODE_CLEAR;
			else                r.mode = MODE_W'($urandom_range(MODE_UNUSED_5, MODE_UNUSED_7));
		end
		// Search mostly for values that are present
		if (r.mode == MODE_LOCATE && list_len > 0 && $urandom_range(0, 99) < 60)
			r.value = list_mem[$urandom_range(0, list_len - 1)];
		// Position: mostly legal with weight on the ends, sometimes out of range
		top = (r.mode == MODE_INSERT) ? list_len + 1 : list_len;
		roll = $urandom_range(0, 99);
		if (roll < 4)       r.position = '0;
		else if (roll < 7)  r.position = POS_W'(top + 1);
		else if (roll < 10) r.position = POS_W'($urandom_range(top + 1, 255));
		else if (top == 0)  r.position = POS_W'(1);
		else if (roll < 25) r.position = POS_W'(1);
		else if (roll < 40) r.position = POS_W'(top);
		else                r.position = POS_W'($urandom_range(1, top));
		return r;
	endfunction

	function automatic list_case_t mk(logic [MODE_W-1:0] m, int p, int v, bit t,
		bit ok, int el, int fp, int cnt, bit emp);
		list_case_t c;
		c.r.mode = m;
		c.r.position = POS_W'(p);
		c.r.value = DATA_W'(v);
		c.typed = t;
		c.want.ok = ok;
		c.want.element = DATA_W'(el);
		c.want.found_position = LEN_W'(fp);
		c.want.count = LEN_W'(cnt);
		c.want.is_empty = emp;
		return c;
	endfunction

	// Offer one item, hold it until taken, then record its expected response
	task automatic send_list_request(sle_req_t r, bit typed, sle_rsp_t typed_rsp);
		sle_rsp_t predicted;
		@(negedge clk);
		while ($urandom_range(0, 99) < idle_pct) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req_valid <= 1'b1;
		req <= r;
		do
			@(posedge clk);
		while (req_stall);
		predicted = apply_list_op(r);
		rsp_q.push_back(typed ? typed_rsp : predicted);
	endtask

	// Receiver: random stalls, plus one long hold-off on request
	initial begin : rsp_side
		int held;
		rsp_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (long_hold) begin
				rsp_stall <= 1'b1;
				for (held = 0; held < HOLD_CYCLES; held++)
					@(negedge clk);
				long_hold = 1'b0;
			end else begin
				rsp_stall <= ($urandom_range(0, 99) < stall_pct);
			end
		end
	end

	// Response checker
	always @(posedge clk) begin : rsp_check
		sle_rsp_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (rsp_q.size() == 0) begin
				$error("response item with none expected");
				err_cnt++;
			end else begin
				want = rsp_q.pop_front();
				if (rsp.ok !== want.ok) begin
					$error("ok: expected %0d, got %0d", want.ok, rsp.ok);
					err_cnt++;
				end
				if (rsp.element !== want.element) begin
					$error("element: expected %0d, got %0d", want.element, rsp.element);
					err_cnt++;
				end
				if (rsp.found_position !== want.found_position) begin
					$error("found_position: expected %0d, got %0d",
						want.found_position, rsp.found_position);
					err_cnt++;
				end
				if (rsp.count !== want.count) begin
					$error("count: expected %0d, got %0d", want.count, rsp.count);
					err_cnt++;
				end
				if (rsp.is_empty !== want.is_empty) begin
					$error("is_empty: expected %0d, got %0d", want.is_empty, rsp.is_empty);
					err_cnt++;
				end
			end
		end
	end

	// Watchdog on handshake activity
	always @(posedge clk) begin
		if (!arst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin : stimulus
		int ph;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		idle_pct = 0;
		stall_pct = 0;
		long_hold = 1'b0;
		filling = 1'b1;
		list_len = 0;

		// Directed cases: empty list, bad positions, ends, first match, bad modes
		cases.push_back(mk(MODE_GET,      1,   8'h00, 1, 0, 8'h00, 0, 0, 1));
		cases.push_back(mk(MODE_DELETE,   1,   8'h00, 1, 0, 8'h00, 0, 0, 1));
		cases.push_back(mk(MODE_LOCATE,   0,   8'h00, 1, 1, 8'h00, 0, 0, 1));
		cases.push_back(mk(MODE_INSERT,   0,   8'h11, 1, 0, 8'h00, 0, 0, 1));
		cases.push_back(mk(MODE_INSERT,   2,   8'h11, 1, 0, 8'h00, 0, 0, 1));
		cases.push_back(mk(MODE_INSERT,   1,   8'hFF, 1, 1, 8'h00, 0, 1, 0));
		cases.push_back(mk(MODE_INSERT,   2,   8'h00, 1, 1, 8'h00, 0, 2, 0));
		cases.push_back(mk(MODE_INSERT,   1,   8'hA5, 1, 1, 8'h00, 0, 3, 0));
		cases.push_back(mk(MODE_GET,      1,   8'h00, 1, 1, 8'hA5, 0, 3, 0));
		cases.push_back(mk(MODE_GET,      3,   8'h00, 0, 0, 8'h00, 0, 0, 0));
		cases.push_back(mk(MODE_GET,      4,   8'h00, 1, 0, 8'h00, 0, 3, 0));
		cases.push_back(mk(MODE_GET,      255, 8'hFF, 1, 0, 8'h00, 0, 3, 0));
		cases.push_back(mk(MODE_LOCATE,   0,   8'hFF, 1, 1, 8'h00, 2, 3, 0));
		cases.push_back(mk(MODE_LOCATE,   0,   8'h5A, 1, 1, 8'h00, 0, 3, 0));
		cases.push_back(mk(MODE_INSERT,   5,   8'h33, 1, 0, 8'h00, 0, 3, 0));
		cases.push_back(mk(MODE_INSERT,   4,   8'hA5, 1, 1, 8'h00, 0, 4, 0));
		cases.push_back(mk(MODE_LOCATE,   0,   8'hA5, 0, 0, 8'h00, 0, 0, 0));
		cases.push_back(mk(MODE_DELETE,   2,   8'h00, 1, 1, 8'hFF, 0, 3, 0));
		cases.push_back(mk(MODE_DELETE,   3,   8'h00, 1, 1, 8'hA5, 0, 2, 0));
		cases.push_back(mk(MODE_UNUSED_5, 1,   8'h00, 1, 0, 8'h00, 0, 2, 0));
		cases.push_back(mk(MODE_UNUSED_7, 255, 8'hFF, 1, 0, 8'h00, 0, 2, 0));
		cases.push_back(mk(MODE_UNUSED_6, 2,   8'h5A, 1, 0, 8'h00, 0, 2, 0));
		cases.push_back(mk(MODE_CLEAR,    0,   8'h00, 1, 1, 8'h00, 0, 0, 1));
		cases.push_back(mk(MODE_GET,      1,   8'h00, 1, 0, 8'h00, 0, 0, 1));

		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (cases[i])
			send_list_request(cases[i].r, cases[i].typed, cases[i].want);

		// Random traffic under four idling mixes
		for (ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin
					idle_pct = 0;
					stall_pct = 0;
					long_hold = 1'b1;  // back up the block while the sender keeps going
				end
				1: begin
					idle_pct = 61;
					stall_pct = 0;
				end
				2: begin
					idle_pct = 0;
					stall_pct = 61;
				end
				default: begin
					idle_pct = 13;
					stall_pct = 13;
				end
			endcase
			repeat (RANDOM_ITEMS / 4)
				send_list_request(next_list_request(), 1'b0, '0);
		end

		@(negedge clk);
		req_valid <= 1'b0;
		wait (rsp_q.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (err_cnt == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
